@@ hdl/rmh_pkg.sv @@
// shared types, sizes and key compare for the run merge min-heap
package rmh_pkg;

  localparam int MAX_RUNS = 64;
  localparam logic [32:0] RUN_LENGTH = 33'd134217728;
  localparam int KMER_LEN = 8;

  localparam int RUN_W   = 6;
  localparam int MARK_W  = 16;
  localparam int SITE_W  = 32;
  localparam int COUNT_W = 27;
  localparam int RUNS_W  = 7;

  localparam logic [MARK_W-1:0] MARK_MASK =
    MARK_W'((34'd1 << (2 * KMER_LEN)) - 34'd1);

  // heap geometry: one cell per tree level
  localparam int LEVELS     = $clog2(MAX_RUNS + 1);
  localparam int SIZE_W     = LEVELS;
  localparam int NODE_W     = SIZE_W + 1;
  localparam int IDX_W      = LEVELS - 1;
  localparam int LVL_W      = $clog2(LEVELS);
  localparam int LAST_ROW   = 1 << (LEVELS - 1);
  localparam int LAST_FILL  = MAX_RUNS - LAST_ROW + 1;
  localparam int PREV_ROW   = LAST_ROW / 2;
  localparam int CELL_DEPTH = (LAST_FILL > PREV_ROW) ? LAST_FILL : PREV_ROW;
  localparam int CELL_AW    = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;

  typedef enum logic {
    FUNC_LOAD    = 1'b0,
    FUNC_ADVANCE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  typedef struct packed {
    func_t               func;
    logic [RUN_W-1:0]    run_id;
    logic [MARK_W-1:0]   mark;
    logic [SITE_W-1:0]   site;
    logic [COUNT_W-1:0]  count;
    logic                next_valid;
  } in_word_t;

  typedef struct packed {
    logic                top_valid;
    logic [RUN_W-1:0]    top_run;
    logic [MARK_W-1:0]   top_mark;
    logic [SITE_W-1:0]   top_site;
    logic [RUNS_W-1:0]   runs_left;
    err_t                error;
  } out_word_t;

  typedef struct packed {
    logic [RUN_W-1:0]    run;
    logic [COUNT_W-1:0]  count;
    logic [MARK_W-1:0]   mark;
    logic [SITE_W-1:0]   site;
  } slot_t;

  // element travelling along the chain
  typedef struct packed {
    logic                valid;
    logic                down;
    logic [IDX_W-1:0]    idx;
    slot_t               ent;
  } tok_t;

  typedef struct packed {
    logic                valid;
    logic [IDX_W-1:0]    a;
    logic [IDX_W-1:0]    b;
  } rd_req_t;

  typedef struct packed {
    logic                valid;
    logic [IDX_W-1:0]    idx;
    slot_t               ent;
  } wr_t;

  function automatic logic key_less(input slot_t a, input slot_t b);
    key_less = (a.mark < b.mark) || ((a.mark == b.mark) && (a.site < b.site));
  endfunction

  function automatic logic [LVL_W-1:0] msb_pos(input logic [NODE_W-1:0] v);
    logic [LVL_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < NODE_W; i++) begin
      if (v[i]) begin
        pos = LVL_W'(i);
      end
    end
    msb_pos = pos;
  endfunction

endpackage

@@ hdl/rmh_cell.sv @@
// one heap level: slot memory plus the compare step for sift up and sift down
module rmh_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [rmh_pkg::LVL_W-1:0]  lvl,
  input  logic [rmh_pkg::SIZE_W-1:0] size,
  input  rmh_pkg::tok_t              start,
  input  rmh_pkg::tok_t              dn_in,
  input  rmh_pkg::tok_t              up_in,
  input  rmh_pkg::rd_req_t           rd_in,
  output rmh_pkg::slot_t             rd_a,
  output rmh_pkg::slot_t             rd_b,
  input  rmh_pkg::slot_t             nb_up,
  input  rmh_pkg::slot_t             nb_dn_a,
  input  rmh_pkg::slot_t             nb_dn_b,
  output rmh_pkg::rd_req_t           up_rd,
  output rmh_pkg::rd_req_t           dn_rd,
  output rmh_pkg::tok_t              up_out,
  output rmh_pkg::tok_t              dn_out,
  output rmh_pkg::wr_t               wr,
  output logic                       done
);
  import rmh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DN_RD,
    S_DN_CMP,
    S_UP_RD,
    S_UP_CMP
  } state_t;

  state_t            state;
  state_t            state_next;
  slot_t             x;
  logic [IDX_W-1:0]  idx;
  slot_t             mem [CELL_DEPTH];

  tok_t              tok;
  logic [NODE_W-1:0] node;
  logic [NODE_W-1:0] lc;
  logic [NODE_W-1:0] rc;
  logic              lcv;
  logic              rcv;
  logic              take_a;
  logic              take_b;

  always_comb begin
    tok    = start.valid ? start : (dn_in.valid ? dn_in : up_in);
    node   = (NODE_W'(1) << lvl) | NODE_W'(idx);
    lc     = NODE_W'({node, 1'b0});
    rc     = lc | NODE_W'(1);
    lcv    = lc <= NODE_W'(size);
    rcv    = rc <= NODE_W'(size);
    take_a = lcv && key_less(nb_dn_a, x);
    take_b = rcv && key_less(nb_dn_b, take_a ? nb_dn_a : x);

    state_next = state;
    up_rd      = '0;
    dn_rd      = '0;
    up_out     = '0;
    dn_out     = '0;
    wr         = '0;
    done       = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (tok.valid) begin
          state_next = tok.down ? S_DN_RD : S_UP_RD;
        end
      end
      S_DN_RD: begin
        if (!lcv) begin
          wr         = '{valid: 1'b1, idx: idx, ent: x};
          done       = 1'b1;
          state_next = S_IDLE;
        end else begin
          dn_rd      = '{valid: 1'b1, a: IDX_W'({idx, 1'b0}), b: IDX_W'({idx, 1'b1})};
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        state_next = S_IDLE;
        wr.valid   = 1'b1;
        wr.idx     = idx;
        if (take_b) begin
          wr.ent = nb_dn_b;
          dn_out = '{valid: 1'b1, down: 1'b1, idx: IDX_W'({idx, 1'b1}), ent: x};
        end else if (take_a) begin
          wr.ent = nb_dn_a;
          dn_out = '{valid: 1'b1, down: 1'b1, idx: IDX_W'({idx, 1'b0}), ent: x};
        end else begin
          wr.ent = x;
          done   = 1'b1;
        end
      end
      S_UP_RD: begin
        if (lvl == '0) begin
          wr         = '{valid: 1'b1, idx: idx, ent: x};
          done       = 1'b1;
          state_next = S_IDLE;
        end else begin
          up_rd      = '{valid: 1'b1, a: idx >> 1, b: idx >> 1};
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        state_next = S_IDLE;
        wr.valid   = 1'b1;
        wr.idx     = idx;
        if (key_less(x, nb_up)) begin
          wr.ent = nb_up;
          up_out = '{valid: 1'b1, down: 1'b0, idx: idx >> 1, ent: x};
        end else begin
          wr.ent = x;
          done   = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
      if (state == S_IDLE && tok.valid) begin
        x   <= tok.ent;
        idx <= tok.idx;
      end
    end
  end

  // slot memory, one write and two registered reads
  always_ff @(posedge clk) begin
    if (wr.valid) begin
      mem[wr.idx[CELL_AW-1:0]] <= wr.ent;
    end
    if (rd_in.valid) begin
      rd_a <= mem[rd_in.a[CELL_AW-1:0]];
      rd_b <= mem[rd_in.b[CELL_AW-1:0]];
    end
  end

endmodule

@@ hdl/run_merge_min_heap_top.sv @@
// run merge min-heap: item sequencer, root copy and the chain of level cells
//
// item channel: item_valid / item_stall carry one word per load or advance.
// a load inserts a run head with its element count; an advance consumes the
// top run, either replacing its head with the supplied next element or
// dropping the run. every item gives exactly one result word on the result
// channel: the top run, mark and site, the runs left and an error code.
// the heap is a chain of level cells, one per tree level, each with its own
// slot memory; a moving element steps one level after each read and compare.
// one item is worked at a time; the next item is taken once the previous
// result sits in the output register, even while the receiver stalls it,
// so no item is taken while the previous one is still being worked.
// a result held under result_stall keeps its word; the block waits with a
// finished item only while a previous result is still stalled.
// reset empties the heap and drops any pending result.
module run_merge_min_heap_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  rmh_pkg::in_word_t  item,
  output logic               result_valid,
  input  logic               result_stall,
  output rmh_pkg::out_word_t result
);
  import rmh_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOVE,
    S_BUSY,
    S_OUT
  } state_t;

  state_t             state;
  logic [SIZE_W-1:0]  size;
  slot_t              root;
  err_t               err;
  out_word_t          res;
  logic               res_valid;
  logic [LVL_W-1:0]   mv_lvl;

  tok_t               start   [LEVELS];
  rd_req_t            ctrl_rd [LEVELS];
  rd_req_t            rd_in   [LEVELS];
  slot_t              rd_a    [LEVELS];
  slot_t              rd_b    [LEVELS];
  rd_req_t            up_rd   [LEVELS];
  rd_req_t            dn_rd   [LEVELS];
  tok_t               up_out  [LEVELS];
  tok_t               dn_out  [LEVELS];
  wr_t                wr      [LEVELS];
  logic [LEVELS-1:0]  done_v;

  logic               accept;
  logic               is_load;
  logic               full;
  logic               empty;
  logic               keep;
  logic [MARK_W-1:0]  mark_m;
  logic [COUNT_W-1:0] cnt_sat;
  logic [COUNT_W-1:0] cdec;
  logic [NODE_W-1:0]  ins_node;
  logic [NODE_W-1:0]  last_node;
  logic [LVL_W-1:0]   ins_lvl;
  logic [LVL_W-1:0]   last_lvl;
  logic [IDX_W-1:0]   ins_idx;
  logic [IDX_W-1:0]   last_idx;

  assign item_stall   = (state != S_IDLE);
  assign accept       = item_valid && !item_stall;
  assign result_valid = res_valid;
  assign result       = res;

  always_comb begin
    is_load   = (item.func == FUNC_LOAD);
    full      = (size >= SIZE_W'(MAX_RUNS));
    empty     = (size == '0);
    mark_m    = item.mark & MARK_MASK;
    cnt_sat   = (33'(item.count) > RUN_LENGTH) ? COUNT_W'(RUN_LENGTH) : item.count;
    cdec      = (root.count == '0) ? '0 : root.count - COUNT_W'(1);
    keep      = (cdec != '0) && item.next_valid;
    ins_node  = NODE_W'(size) + NODE_W'(1);
    last_node = NODE_W'(size);
    ins_lvl   = msb_pos(ins_node);
    last_lvl  = msb_pos(last_node);
    ins_idx   = IDX_W'(ins_node ^ (NODE_W'(1) << ins_lvl));
    last_idx  = IDX_W'(last_node ^ (NODE_W'(1) << last_lvl));

    for (int k = 0; k < LEVELS; k++) begin
      start[k]   = '0;
      ctrl_rd[k] = '0;
      if (accept && is_load && !full && ins_lvl == LVL_W'(k)) begin
        start[k] = '{valid: 1'b1, down: 1'b0, idx: ins_idx,
                     ent: '{run: item.run_id, count: cnt_sat, mark: mark_m,
                            site: item.site}};
      end
      if (accept && !is_load && !empty && keep && k == 0) begin
        start[k] = '{valid: 1'b1, down: 1'b1, idx: '0,
                     ent: '{run: root.run, count: cdec, mark: mark_m,
                            site: item.site}};
      end
      // fetch the last slot, it moves to the top
      if (accept && !is_load && !empty && !keep && size != SIZE_W'(1)
          && last_lvl == LVL_W'(k)) begin
        ctrl_rd[k] = '{valid: 1'b1, a: last_idx, b: last_idx};
      end
      if (state == S_MOVE && k == 0) begin
        start[k] = '{valid: 1'b1, down: 1'b1, idx: '0, ent: rd_a[mv_lvl]};
      end
    end
  end

  for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
    tok_t    dn_src;
    tok_t    up_src;
    rd_req_t from_above;
    rd_req_t from_below;
    slot_t   up_d;
    slot_t   dn_da;
    slot_t   dn_db;

    if (k == 0) begin : g_first
      assign dn_src     = '0;
      assign from_above = '0;
      assign up_d       = '0;
    end else begin : g_mid_up
      assign dn_src     = dn_out[k-1];
      assign from_above = dn_rd[k-1];
      assign up_d       = rd_a[k-1];
    end

    if (k == LEVELS - 1) begin : g_last
      assign up_src     = '0;
      assign from_below = '0;
      assign dn_da      = '0;
      assign dn_db      = '0;
    end else begin : g_mid_dn
      assign up_src     = up_out[k+1];
      assign from_below = up_rd[k+1];
      assign dn_da      = rd_a[k+1];
      assign dn_db      = rd_b[k+1];
    end

    assign rd_in[k] = ctrl_rd[k].valid ? ctrl_rd[k]
                    : (from_above.valid ? from_above : from_below);

    rmh_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .lvl     (LVL_W'(k)),
      .size    (size),
      .start   (start[k]),
      .dn_in   (dn_src),
      .up_in   (up_src),
      .rd_in   (rd_in[k]),
      .rd_a    (rd_a[k]),
      .rd_b    (rd_b[k]),
      .nb_up   (up_d),
      .nb_dn_a (dn_da),
      .nb_dn_b (dn_db),
      .up_rd   (up_rd[k]),
      .dn_rd   (dn_rd[k]),
      .up_out  (up_out[k]),
      .dn_out  (dn_out[k]),
      .wr      (wr[k]),
      .done    (done_v[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      size      <= '0;
      res_valid <= 1'b0;
      err       <= ERR_OK;
    end else begin
      // root copy follows every write into the top level
      if (wr[0].valid) begin
        root <= wr[0].ent;
      end
      if (res_valid && !result_stall && state != S_OUT) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_load) begin
              if (full) begin
                err   <= ERR_FULL;
                state <= S_OUT;
              end else begin
                err   <= ERR_OK;
                size  <= size + SIZE_W'(1);
                state <= S_BUSY;
              end
            end else if (empty) begin
              err   <= ERR_EMPTY;
              state <= S_OUT;
            end else begin
              err <= ERR_OK;
              if (keep) begin
                state <= S_BUSY;
              end else begin
                size <= size - SIZE_W'(1);
                if (size == SIZE_W'(1)) begin
                  state <= S_OUT;
                end else begin
                  mv_lvl <= last_lvl;
                  state  <= S_MOVE;
                end
              end
            end
          end
        end
        S_MOVE: begin
          state <= S_BUSY;
        end
        S_BUSY: begin
          if (|done_v) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_valid || !result_stall) begin
            res.top_valid <= (size != '0);
            res.top_run   <= (size != '0) ? root.run : '0;
            res.top_mark  <= (size != '0) ? root.mark : '0;
            res.top_site  <= (size != '0) ? root.site : '0;
            res.runs_left <= RUNS_W'(size);
            res.error     <= err;
            res_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/tb_run_merge_min_heap_top.sv @@
// testbench for the run merge min-heap: load and advance words checked against a heap predictor
module tb_run_merge_min_heap_top;
  import rmh_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 900;
  localparam int SETTLE_CYCLES = 40;

  class heap_tracker;
    slot_t       cells[MAX_RUNS];
    int          fill;
    out_word_t   tops_due[$];
    int unsigned mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    function int waiting();
      return tops_due.size();
    endfunction

    function bit ranks_below(int a, int b);
      if (cells[a].mark != cells[b].mark) begin
        return cells[a].mark < cells[b].mark;
      end
      return cells[a].site < cells[b].site;
    endfunction

    function void trade(int a, int b);
      slot_t t;
      t = cells[a];
      cells[a] = cells[b];
      cells[b] = t;
    endfunction

    function void note_item(in_word_t w);
      out_word_t want;
      err_t      code;
      int        pos;
      int        best;
      int        kid;
      bit        moving;
      code = ERR_OK;
      if (w.func == FUNC_LOAD) begin
        if (fill >= MAX_RUNS) begin
          code = ERR_FULL;
        end else begin
          pos = fill;
          cells[pos].run   = w.run_id;
          // a 27-bit count never exceeds the run length
          cells[pos].count = w.count;
          cells[pos].mark  = w.mark & MARK_MASK;
          cells[pos].site  = w.site;
          fill++;
          while (pos > 0 && ranks_below(pos, (pos - 1) / 2)) begin
            trade(pos, (pos - 1) / 2);
            pos = (pos - 1) / 2;
          end
        end
      end else if (fill == 0) begin
        code = ERR_EMPTY;
      end else begin
        if (cells[0].count != 0) begin
          cells[0].count = cells[0].count - 1'b1;
        end
        if (cells[0].count != 0 && w.next_valid) begin
          cells[0].mark = w.mark & MARK_MASK;
          cells[0].site = w.site;
        end else begin
          trade(0, fill - 1);
          fill--;
        end
        pos = 0;
        moving = 1'b1;
        while (moving) begin
          best = pos;
          kid = 2 * pos + 1;
          if (kid < fill && ranks_below(kid, best)) begin
            best = kid;
          end
          if (kid + 1 < fill && ranks_below(kid + 1, best)) begin
            best = kid + 1;
          end
          moving = (best != pos);
          if (moving) begin
            trade(pos, best);
            pos = best;
          end
        end
      end
      want = '0;
      if (fill > 0) begin
        want.top_valid = 1'b1;
        want.top_run   = cells[0].run;
        want.top_mark  = cells[0].mark;
        want.top_site  = cells[0].site;
      end
      want.runs_left = RUNS_W'(fill);
      want.error = code;
      tops_due.push_back(want);
    endfunction

    function string show(out_word_t w);
      return $sformatf("valid=%0b run=%0d mark=%h site=%h left=%0d err=%0d",
                       w.top_valid, w.top_run, w.top_mark, w.top_site, w.runs_left, w.error);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (tops_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result word: %s", show(got));
        end
      end else begin
        want = tops_due.pop_front();
        if (got.top_valid !== want.top_valid || got.top_run !== want.top_run ||
            got.top_mark !== want.top_mark || got.top_site !== want.top_site ||
            got.runs_left !== want.runs_left || got.error !== want.error) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected %s, got %s", show(want), show(got));
          end
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  in_word_t    item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  out_word_t   result;
  bit          quiet = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  heap_tracker tracker = new();

  run_merge_min_heap_top u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic bit take_break();
    return !quiet && ($urandom_range(99) < 9);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        tracker.check_result(result);
      end
      result_stall <= take_break();
    end
  end

  function automatic in_word_t load_word(logic [RUN_W-1:0] run, logic [MARK_W-1:0] mark,
                                         logic [SITE_W-1:0] site, logic [COUNT_W-1:0] cnt);
    in_word_t w;
    w.func       = FUNC_LOAD;
    w.run_id     = run;
    w.mark       = mark;
    w.site       = site;
    w.count      = cnt;
    w.next_valid = 1'($urandom);
    return w;
  endfunction

  function automatic in_word_t advance_word(logic nv, logic [MARK_W-1:0] mark,
                                            logic [SITE_W-1:0] site);
    in_word_t w;
    w.func       = FUNC_ADVANCE;
    w.run_id     = RUN_W'($urandom);
    w.mark       = mark;
    w.site       = site;
    w.count      = COUNT_W'($urandom);
    w.next_valid = nv;
    return w;
  endfunction

  function automatic logic [MARK_W-1:0] pick_mark();
    return ($urandom_range(99) < 30) ? MARK_W'($urandom_range(7)) : MARK_W'($urandom);
  endfunction

  function automatic logic [SITE_W-1:0] pick_site();
    return ($urandom_range(99) < 5) ? SITE_W'($urandom_range(3)) : SITE_W'($urandom);
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 60) begin
      return COUNT_W'($urandom_range(4));
    end
    if (r < 85) begin
      return COUNT_W'($urandom_range(40, 5));
    end
    return COUNT_W'($urandom);
  endfunction

  function automatic in_word_t random_item(int load_pct, int drop_pct);
    if ($urandom_range(99) < load_pct) begin
      return load_word(RUN_W'($urandom), pick_mark(), pick_site(), pick_count());
    end
    return advance_word(1'($urandom_range(99) >= drop_pct), pick_mark(), pick_site());
  endfunction

  task automatic send_item(input in_word_t w);
    if (take_break()) begin
      item_valid <= 1'b0;
      do @(posedge clk); while (take_break());
    end
    item_valid <= 1'b1;
    item <= w;
    do @(posedge clk); while (item_stall);
    tracker.note_item(w);
    items_sent++;
  endtask

  task automatic hold_until_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (tracker.waiting() != 0);
  endtask

  initial begin
    int phase_len;
    int load_pct;
    int drop_pct;
    bit paused;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty heap, zero count, extremes, repeated run, equal keys
    send_item(advance_word(1'b1, 16'h1234, 32'h0000_0001));
    send_item(load_word(6'd0, 16'h0000, 32'h0000_0000, 27'd0));
    send_item(advance_word(1'b1, 16'h0001, 32'h0000_0005));
    send_item(load_word(6'd63, 16'hffff, 32'hffff_ffff, 27'h7ff_ffff));
    send_item(load_word(6'd5, 16'h0010, 32'd100, 27'd1));
    send_item(load_word(6'd5, 16'h0010, 32'd50, 27'd3));
    send_item(load_word(6'd7, 16'h0010, 32'd50, 27'd2));
    send_item(load_word(6'd1, 16'h0000, 32'hffff_ffff, 27'd2));
    send_item(load_word(6'd2, 16'hffff, 32'h0000_0000, 27'd1));
    send_item(advance_word(1'b1, 16'h0020, 32'd7));
    send_item(advance_word(1'b1, 16'h0000, 32'h0000_0000));
    send_item(advance_word(1'b1, 16'hffff, 32'hffff_ffff));
    repeat (8) send_item(advance_word(1'b0, pick_mark(), pick_site()));
    hold_until_drained();

    // fill past capacity, then empty the heap
    repeat (MAX_RUNS + 4) send_item(random_item(100, 0));
    while (tracker.fill != 0) begin
      send_item(random_item(0, 60));
    end
    send_item(random_item(0, 0));

    while (items_sent < RANDOM_ITEMS - 40) begin
      case ($urandom_range(2))
        0: load_pct = 80;
        1: load_pct = 25;
        default: load_pct = 50;
      endcase
      drop_pct = $urandom_range(40, 5);
      phase_len = $urandom_range(80, 20);
      repeat (phase_len) begin
        quiet = (items_sent >= 350 && items_sent < 550);
        send_item(random_item(load_pct, drop_pct));
      end
      if (!paused && items_sent >= 600) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end
    quiet = 1'b0;

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.waiting() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/rmh_pkg.sv
hdl/rmh_cell.sv
hdl/run_merge_min_heap_top.sv
tb/tb_run_merge_min_heap_top.sv
